>>> hw/rtl/dbi_pkg.sv
// ----------------------------------------------------------------------------
// dbi_pkg
// Shared constants for the distance to beat interval core: register reset
// values, register indexes, operation codes and status codes.
// ----------------------------------------------------------------------------
package dbi_pkg;

   localparam int unsigned DEF_FRAC_BITS = 8;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DATA_W    = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NEAR      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FAR       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_IVL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_IVL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHG_THR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_THR  = 3'd6;

   // register reset values
   localparam logic [DATA_W-1:0] RST_NEAR     = 16'd100;
   localparam logic [DATA_W-1:0] RST_FAR      = 16'd1000;
   localparam logic [DATA_W-1:0] RST_MIN_IVL  = 16'd50;
   localparam logic [DATA_W-1:0] RST_MAX_IVL  = 16'd5000;
   localparam logic [DATA_W-1:0] RST_CHG_THR  = 16'd20;
   localparam logic [DATA_W-1:0] RST_ALPHA    = 16'd22938;
   localparam logic [DATA_W-1:0] RST_JUMP_THR = 16'd80;

   // operation codes
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_BOOT   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // status codes
   localparam logic [2:0] STAT_NONE    = 3'd0;
   localparam logic [2:0] STAT_NEW     = 3'd1;
   localparam logic [2:0] STAT_HELD    = 3'd2;
   localparam logic [2:0] STAT_BOOTED  = 3'd3;
   localparam logic [2:0] STAT_CLEARED = 3'd4;

   // rounding offset for the Q0.16 filter weight
   localparam int unsigned HALF_Q16 = 32768;
   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [15:0] IVL_SAT  = 16'hFFFF;

endpackage

>>> hw/rtl/distance_to_beat_interval_core.sv
// ----------------------------------------------------------------------------
// distance_to_beat_interval_core
// Smooths distance readings with a low-pass filter and maps the filtered
// distance to a rounded, clamped beat interval in ms.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_op, req_distance_mm
//  rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_interval_ms
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  An update item computes its ratio and then its interval on one shared
//  shift-subtract divider, plus the steps on one shared multiplier. Clear,
//  zero readings, repeat bootstraps and the unused op are answered from the
//  decode state. One item is in flight at a time; req_stall is high until
//  the result transfers. Synchronous reset empties the filter and loads the
//  register defaults; csr_ready is always high.
// ----------------------------------------------------------------------------
module distance_to_beat_interval_core
   import dbi_pkg::*;
#(
   parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [DATA_W-1:0]    req_distance_mm,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [DATA_W-1:0]    rsp_interval_ms,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int unsigned FW = DATA_W + FRAC_BITS;   // filter width
   localparam int unsigned PW = FW + DATA_W;          // product width
   localparam int unsigned DW = 2 * DATA_W + 1;       // divider width
   localparam int unsigned RW = DATA_W + 1;           // ratio width

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FILT_MUL, S_FILT_ADD, S_MAP, S_RDIV,
      S_MUL_NN, S_MUL_D1, S_MUL_D2, S_SUM, S_IDIV_SET, S_IDIV,
      S_CLAMP, S_DECIDE, S_DONE
   } state_type;

   state_type         state_ff, state_in;

   logic [DATA_W-1:0] near_ff, far_ff, min_ff, max_ff, chg_ff, alpha_ff, jump_ff;

   logic [FW-1:0]     filt_ff, filt_in;
   logic [DATA_W-1:0] last_ff, last_in;

   logic [1:0]        op_ff, op_in;
   logic [DATA_W-1:0] dist_ff, dist_in;
   logic [FW-1:0]     fw_ff, fw_in;
   logic [FW-1:0]     e_ff, e_in;
   logic              up_ff, up_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [RW-1:0]     r_ff, r_in;
   logic [31:0]       nh_ff, nh_in;
   logic [DW-1:0]     d_ff, d_in;
   logic [DW-1:0]     rem_ff, rem_in, den_ff, den_in;
   logic [DATA_W-1:0] low_ff, low_in, quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [DATA_W-1:0] iv_ff, iv_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_ivl_ff, rsp_ivl_in;

   logic [FW-1:0]     x, lo, hi, jump_fx, s;
   logic [PW-1:0]     s_sum;
   logic [FW-1:0]     mul_a;
   logic [DATA_W-1:0] mul_b;
   logic [DW:0]       rem_sh;
   logic              ge;
   logic [DW-1:0]     rem_step;
   logic [DATA_W-1:0] quo_step, iv_lo, iv_diff;

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_interval_ms = rsp_ivl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff  <= RST_NEAR;
         far_ff   <= RST_FAR;
         min_ff   <= RST_MIN_IVL;
         max_ff   <= RST_MAX_IVL;
         chg_ff   <= RST_CHG_THR;
         alpha_ff <= RST_ALPHA;
         jump_ff  <= RST_JUMP_THR;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NEAR:     near_ff  <= csr_wdata;
            REG_FAR:      far_ff   <= csr_wdata;
            REG_MIN_IVL:  min_ff   <= csr_wdata;
            REG_MAX_IVL:  max_ff   <= csr_wdata;
            REG_CHG_THR:  chg_ff   <= csr_wdata;
            REG_ALPHA:    alpha_ff <= csr_wdata;
            REG_JUMP_THR: jump_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared datapath terms
   assign x       = {dist_ff, {FRAC_BITS{1'b0}}};
   assign lo      = {near_ff, {FRAC_BITS{1'b0}}};
   assign hi      = {far_ff, {FRAC_BITS{1'b0}}};
   assign jump_fx = {jump_ff, {FRAC_BITS{1'b0}}};
   assign s_sum   = prod_ff + PW'(HALF_Q16);
   assign s       = s_sum[DATA_W +: FW];

   assign rem_sh   = {rem_ff, low_ff[DATA_W-1]};
   assign ge       = (rem_sh >= {1'b0, den_ff});
   assign rem_step = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
   assign quo_step = {quo_ff[DATA_W-2:0], ge};

   assign iv_lo   = (iv_ff < min_ff) ? min_ff : iv_ff;
   assign iv_diff = (iv_ff > last_ff) ? (iv_ff - last_ff) : (last_ff - iv_ff);

   always_comb begin
      mul_a = e_ff;
      mul_b = alpha_ff;
      case (state_ff)
         S_MUL_NN: begin
            mul_a = FW'(min_ff);
            mul_b = max_ff;
         end
         S_MUL_D1: begin
            mul_a = FW'(ONE_Q16 - r_ff);
            mul_b = max_ff;
         end
         S_MUL_D2: begin
            mul_a = FW'(r_ff);
            mul_b = min_ff;
         end
         default: ;
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      state_in      = state_ff;
      filt_in       = filt_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      dist_in       = dist_ff;
      fw_in         = fw_ff;
      e_in          = e_ff;
      up_in         = up_ff;
      r_in          = r_ff;
      nh_in         = nh_ff;
      d_in          = d_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      low_in        = low_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      iv_in         = iv_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ivl_in    = rsp_ivl_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               dist_in  = req_distance_mm;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rsp_status_in = STAT_NONE;
            rsp_ivl_in    = '0;
            state_in      = S_DONE;
            rsp_valid_in  = 1'b1;
            up_in         = (x >= filt_ff);
            e_in          = (x >= filt_ff) ? (x - filt_ff) : (filt_ff - x);
            fw_in         = x;
            case (op_ff)
               OP_CLEAR: begin
                  filt_in       = '0;
                  last_in       = '0;
                  rsp_status_in = STAT_CLEARED;
               end
               OP_BOOT: begin
                  if (dist_ff == '0) begin
                     rsp_status_in = STAT_NONE;
                  end else if (last_ff != '0) begin
                     rsp_status_in = STAT_BOOTED;
                     rsp_ivl_in    = last_ff;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_MAP;
                  end
               end
               OP_UPDATE: begin
                  if (dist_ff != '0) begin
                     rsp_valid_in = 1'b0;
                     if (filt_ff == '0 || e_in >= jump_fx) begin
                        state_in = S_MAP;
                     end else begin
                        state_in = S_FILT_MUL;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_FILT_MUL: begin
            state_in = S_FILT_ADD;
         end
         S_FILT_ADD: begin
            fw_in    = up_ff ? (filt_ff + s) : (filt_ff - s);
            state_in = S_MAP;
         end
         S_MAP: begin
            filt_in = fw_ff;
            rem_in  = DW'(fw_ff - lo);
            den_in  = DW'(hi - lo);
            low_in  = '0;
            quo_in  = '0;
            cnt_in  = '0;
            if (fw_ff <= lo) begin
               r_in     = '0;
               state_in = S_MUL_NN;
            end else if (fw_ff >= hi) begin
               r_in     = ONE_Q16;
               state_in = S_MUL_NN;
            end else begin
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            rem_in = rem_step;
            low_in = low_ff << 1;
            quo_in = quo_step;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'hF) begin
               r_in     = {1'b0, quo_step};
               state_in = S_MUL_NN;
            end
         end
         S_MUL_NN: begin
            state_in = S_MUL_D1;
         end
         S_MUL_D1: begin
            nh_in    = prod_ff[31:0];
            state_in = S_MUL_D2;
         end
         S_MUL_D2: begin
            d_in     = prod_ff[DW-1:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            d_in     = d_ff + prod_ff[DW-1:0];
            state_in = S_IDIV_SET;
         end
         S_IDIV_SET: begin
            rem_in = {nh_ff, 1'b0} + {{DATA_W{1'b0}}, d_ff[DW-1:DATA_W]};
            den_in = {d_ff[DW-2:0], 1'b0};
            low_in = d_ff[DATA_W-1:0];
            quo_in = '0;
            cnt_in = '0;
            if (d_ff == '0) begin
               iv_in    = IVL_SAT;
               state_in = S_CLAMP;
            end else begin
               state_in = S_IDIV;
            end
         end
         S_IDIV: begin
            rem_in = rem_step;
            low_in = low_ff << 1;
            quo_in = quo_step;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'hF) begin
               iv_in    = quo_step;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            iv_in    = (iv_lo > max_ff) ? max_ff : iv_lo;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_DONE;
            if (op_ff == OP_BOOT || last_ff == '0 || iv_diff >= chg_ff) begin
               last_in       = iv_ff;
               rsp_status_in = STAT_NEW;
               rsp_ivl_in    = iv_ff;
            end else begin
               rsp_status_in = STAT_HELD;
               rsp_ivl_in    = '0;
            end
         end
         S_DONE: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filt_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      dist_ff       <= dist_in;
      fw_ff         <= fw_in;
      e_ff          <= e_in;
      up_ff         <= up_in;
      prod_ff       <= prod_in;
      r_ff          <= r_in;
      nh_ff         <= nh_in;
      d_ff          <= d_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      low_ff        <= low_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      iv_ff         <= iv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ivl_ff    <= rsp_ivl_in;
   end

endmodule

>>> hw/rtl/dbi_checker.sv
// ----------------------------------------------------------------------------
// dbi_checker
// Port-level checks for the distance to beat interval core, bound to the
// top level.
// ----------------------------------------------------------------------------
module dbi_checker
   import dbi_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_status,
   input logic [DATA_W-1:0] rsp_interval_ms
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_interval_ms))
      else $error("stalled result changed");

   // one item in flight: busy after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // no new input while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open with result pending");

   // only new and bootstrapped results carry an interval
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NONE || rsp_status == STAT_HELD
                    || rsp_status == STAT_CLEARED) |-> rsp_interval_ms == '0)
      else $error("interval on a status without one");

   // status codes stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_CLEARED)
      else $error("status out of range");

endmodule

bind distance_to_beat_interval_core dbi_checker u_dbi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_interval_ms (rsp_interval_ms)
);
